[src/ppu_pkg.sv]
package ppu_pkg;

  // Byte width of one color or alpha channel.
  localparam int unsigned CHAN_W = 8;

  // Width of a packed palette word and of one channel product.
  localparam int unsigned WORD_W = 4 * CHAN_W;
  localparam int unsigned PROD_W = 2 * CHAN_W;

  // Default palette size and queue depth.
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Group geometry for the block swap.
  localparam int unsigned GROUP_W = 5;
  localparam logic [GROUP_W-1:0] HOLD_FIRST = 5'd8;
  localparam logic [GROUP_W-1:0] HOLD_END = 5'd16;
  localparam logic [GROUP_W-1:0] DRAIN_PLACE = 5'd23;

  // Held block of eight entries.
  localparam int unsigned HELD_DEPTH = 8;
  localparam int unsigned SLOT_W = $clog2(HELD_DEPTH);

  // Alpha expansion threshold and full scale.
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'h80;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // What the back end does with a queued word.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_HOLD  = 2'd1,
    KIND_DRAIN = 2'd2
  } cmd_kind_t;

  // One result word in emitted byte order, first byte lowest.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] third;
    logic [CHAN_W-1:0] second;
    logic [CHAN_W-1:0] first;
  } pixel_t;

  // Entry of the queue between front and back.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    pixel_t            word;
  } cmd_t;

  // Source alpha of 0x80 or more is opaque, smaller values are doubled.
  function automatic logic [CHAN_W-1:0] expand_alpha(input logic [CHAN_W-1:0] a);
    logic [CHAN_W-1:0] res;
    if (a >= ALPHA_OPAQUE) begin
      res = CHAN_MAX;
    end else begin
      res = {a[CHAN_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Floor of a channel product divided by 255. The estimate is exact or
  // one short, so a single compare and increment corrects it.
  function automatic logic [CHAN_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] sum;
    logic [CHAN_W-1:0] est;
    logic [PROD_W-1:0] back;
    logic [PROD_W-1:0] rem;
    logic [CHAN_W-1:0] res;
    sum  = x + (x >> CHAN_W);
    est  = sum[PROD_W-1:CHAN_W];
    back = {est, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, est};
    rem  = x - back;
    if (rem >= {{CHAN_W{1'b0}}, CHAN_MAX}) begin
      res = est + 1'b1;
    end else begin
      res = est;
    end
    return res;
  endfunction

endpackage

[src/ppu_channels.sv]
// Incoming palette entry channel.
interface ppu_entry_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

// Outgoing premultiplied word channel.
interface ppu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;
  logic [7:0] out_alpha;
  logic       run_last;

  modport source (output valid, output out_first, output out_second,
                  output out_third, output out_alpha, output run_last, input ready);
  modport sink (input valid, input out_first, input out_second, input out_third,
                input out_alpha, input run_last, output ready);
endinterface

[src/ppu_front.sv]
module ppu_front #(
  parameter int unsigned PALETTE_ENTRIES = ppu_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          enable,
  ppu_entry_if.sink     entry,
  output logic          push_valid,
  input  logic          push_ready,
  output ppu_pkg::cmd_t push_data
);
  import ppu_pkg::*;

  localparam int unsigned POS_W = $clog2(PALETTE_ENTRIES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PALETTE_ENTRIES - 1);

  logic [POS_W-1:0]   pos;
  logic [GROUP_W-1:0] place;
  logic               accept;
  logic [CHAN_W-1:0]  alpha_x;
  cmd_kind_t          kind_now;

  // Product stage between the multipliers and the divide correction.
  logic              stg_valid;
  cmd_kind_t         stg_kind;
  logic [SLOT_W-1:0] stg_slot;
  logic [CHAN_W-1:0] stg_alpha;
  logic [PROD_W-1:0] prod_b;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_r;

  assign entry.ready = !stg_valid || push_ready;
  assign accept      = entry.valid && entry.ready;
  assign place       = pos[GROUP_W-1:0];
  assign alpha_x     = expand_alpha(entry.in_alpha);

  // Classify the entry by its place in the 32-entry group.
  always_comb begin
    kind_now = KIND_PASS;
    if (enable && place >= HOLD_FIRST && place < HOLD_END) begin
      kind_now = KIND_HOLD;
    end else if (enable && place == DRAIN_PLACE) begin
      kind_now = KIND_DRAIN;
    end
  end

  // Palette position, wrapping after the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (pos == POS_LAST) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (entry.ready) begin
      stg_valid <= entry.valid;
    end
  end

  // The three channel products are registered before the divide.
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind  <= kind_now;
      stg_slot  <= place[SLOT_W-1:0];
      stg_alpha <= alpha_x;
      prod_b    <= PROD_W'(entry.in_blue) * PROD_W'(alpha_x);
      prod_g    <= PROD_W'(entry.in_green) * PROD_W'(alpha_x);
      prod_r    <= PROD_W'(entry.in_red) * PROD_W'(alpha_x);
    end
  end

  // Finish the premultiply and hand the word to the queue.
  assign push_valid          = stg_valid;
  assign push_data.kind      = stg_kind;
  assign push_data.slot      = stg_slot;
  assign push_data.word.first  = div_full_scale(prod_b);
  assign push_data.word.second = div_full_scale(prod_g);
  assign push_data.word.third  = div_full_scale(prod_r);
  assign push_data.word.alpha  = stg_alpha;

endmodule

[src/ppu_queue.sv]
module ppu_queue #(
  parameter int unsigned DEPTH = ppu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ppu_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ppu_pkg::cmd_t pop_data
);
  import ppu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[src/ppu_back.sv]
module ppu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ppu_pkg::cmd_t pop_data,
  ppu_result_if.source  result
);
  import ppu_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_t;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HELD_DEPTH - 1);

  back_state_t       state;
  back_state_t       state_next;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] cnt_next;
  pixel_t            held [HELD_DEPTH];
  logic              hold_we;
  logic              can_load;
  logic              load;
  pixel_t            load_word;
  logic              load_last;
  logic              ov;
  pixel_t            out_word;
  logic              out_last;

  assign can_load = !ov || result.ready;

  // Sequencer: pass words on, store held ones, and replay the held block.
  always_comb begin
    pop_ready  = 1'b0;
    hold_we    = 1'b0;
    load       = 1'b0;
    load_word  = pop_data.word;
    load_last  = 1'b0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_RUN: begin
        if (pop_valid) begin
          case (pop_data.kind)
            KIND_HOLD: begin
              pop_ready = 1'b1;
              hold_we   = 1'b1;
            end
            KIND_PASS: begin
              if (can_load) begin
                pop_ready = 1'b1;
                load      = 1'b1;
                load_last = 1'b1;
              end
            end
            KIND_DRAIN: begin
              if (can_load) begin
                pop_ready  = 1'b1;
                load       = 1'b1;
                cnt_next   = '0;
                state_next = ST_DRAIN;
              end
            end
            default: begin
              pop_ready = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (can_load) begin
          load      = 1'b1;
          load_word = held[cnt];
          load_last = (cnt == SLOT_LAST);
          cnt_next  = cnt + 1'b1;
          if (cnt == SLOT_LAST) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Held block store.
  always_ff @(posedge clk) begin
    if (hold_we) begin
      held[pop_data.slot] <= pop_data.word;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
      out_last <= load_last;
    end
  end

  assign result.valid      = ov;
  assign result.out_first  = out_word.first;
  assign result.out_second = out_word.second;
  assign result.out_third  = out_word.third;
  assign result.out_alpha  = out_word.alpha;
  assign result.run_last   = out_last;

  // An output word is always pending while the block replays.
  a_drain_has_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> ov)
    else $error("drain state without a pending output word");

  // A drain starts only from a drain word taken off the queue.
  a_drain_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DRAIN) |-> $past(pop_valid && pop_ready && pop_data.kind == KIND_DRAIN))
    else $error("drain started without a drain word");

  // No word marked last is shown while the replay is still running.
  a_drain_not_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> !(result.valid && result.run_last))
    else $error("last marker before the end of a drain");

endmodule

[src/palette_premultiply_unswizzle.sv]
// Palette alpha premultiply with optional block unswizzle.
//
// Palette entries arrive on the entry channel as red, green, blue and alpha
// bytes; results leave on the result channel as premultiplied blue, green,
// red and expanded alpha, with run_last on the last word caused by an entry.
// Both channels move one word on a clock edge where valid and ready are high.
// The unswizzle register sits at address 0 of the APB port and is to be written
// only while the block is idle; the block itself does not enforce this.
//
// The channel products are registered on the edge that takes the entry, the
// divide correction is then written into the queue, and the output register is
// loaded from the queue. Entries are taken one per cycle until the queue and
// product stage fill. With unswizzle on, entries 8 to 15 of each group give no
// word and entry 23 gives nine words, one at a time through the single output
// register; the queue lets the front go on taking entries during that replay
// until it fills.
//
// Reset clears the palette position, the register, the queue and the output
// register; the held block is undefined until written. When the receiver
// stalls, the output word holds, the queue fills and then entry ready drops.
module palette_premultiply_unswizzle #(
  parameter int unsigned PALETTE_ENTRIES = ppu_pkg::PALETTE_ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH = ppu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  ppu_entry_if.sink    entry,
  ppu_result_if.source result
);
  import ppu_pkg::*;

  localparam logic REG_UNSWIZZLE = 1'b0;

  logic unswizzle_enable;
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unswizzle_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_UNSWIZZLE) begin
      unswizzle_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_UNSWIZZLE) begin
      prdata[0] = unswizzle_enable;
    end
  end

  ppu_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (unswizzle_enable),
    .entry     (entry),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  ppu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  ppu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .result   (result)
  );

endmodule
